[rtl/core/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define QJTG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qjtg assertion failed");

// next-cycle implication, reset masks the check
`define QJTG_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qjtg assertion failed");

`endif

[rtl/core/qjtg_pkg.sv]
// types and constants of the quintic joint trajectory generator
package qjtg_pkg;

	localparam int JOINT_COUNT = 4;
	localparam int ANGLE_W     = 8;
	localparam int MS_W        = 16;
	localparam int Q16_W       = 16;
	localparam int BLEND_W     = 17;
	localparam int LACC_W      = 24;

	// op codes carried in s_tuser
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// unity in q1.16, the top of the blend range
	localparam logic [BLEND_W-1:0] BLEND_ONE = 17'h10000;

	typedef struct packed {
		logic               valid;
		logic [BLEND_W-1:0] blend;
	} blend_res_t;

endpackage

[rtl/core/qjtg_blend.sv]
// serial divider, power chain and minimum-jerk blend polynomial
module qjtg_blend import qjtg_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [MS_W-1:0] elapsed,
	input  logic [MS_W-1:0] duration,
	output blend_res_t      res
);

	localparam logic [1:0] BS_IDLE = 2'd0;
	localparam logic [1:0] BS_DIV  = 2'd1;
	localparam logic [1:0] BS_MUL  = 2'd2;
	localparam logic [1:0] BS_SUM  = 2'd3;

	logic [1:0]       bst_q;
	logic [3:0]       cnt_q;
	logic [1:0]       pass_q;
	logic [MS_W-1:0]  rem_q;
	logic [MS_W-1:0]  dvs_q;
	logic [Q16_W-1:0] quo_q;
	logic [Q16_W-1:0] s_q;
	logic [Q16_W-1:0] mpl_q;
	logic [Q16_W-1:0] pw_q;
	logic [Q16_W-1:0] acc_q;
	logic [Q16_W-1:0] p3_q;
	logic [Q16_W-1:0] p4_q;
	blend_res_t       res_q;

	logic [MS_W:0]    rem2;
	logic [MS_W:0]    rem_diff;
	logic             rem_ge;
	logic [Q16_W-1:0] s_new;
	logic [Q16_W:0]   mul_sum;
	logic [Q16_W-1:0] prod;
	logic [21:0]      t3;
	logic [21:0]      t4;
	logic [21:0]      t5;
	logic [21:0]      poly;
	logic [BLEND_W-1:0] blend_clamped;

	// restoring division step, one quotient bit per cycle
	always_comb begin
		rem2     = {rem_q, 1'b0};
		rem_diff = rem2 - {1'b0, dvs_q};
		rem_ge   = (rem2 >= {1'b0, dvs_q});
		s_new    = {quo_q[Q16_W-2:0], rem_ge};
	end

	// lsb-first shift-add, keeps only the upper half
	always_comb begin
		mul_sum = {1'b0, acc_q} + (mpl_q[0] ? {1'b0, pw_q} : {(Q16_W+1){1'b0}});
		prod    = mul_sum[Q16_W:1];
	end

	// 10 p3 - 15 p4 + 6 p5, p5 sits in pw_q, then clamp to [0, 1]
	always_comb begin
		t3   = ({6'd0, p3_q} << 3) + ({6'd0, p3_q} << 1);
		t4   = ({6'd0, p4_q} << 4) - {6'd0, p4_q};
		t5   = ({6'd0, pw_q} << 2) + ({6'd0, pw_q} << 1);
		poly = t3 - t4 + t5;
		if (poly[21]) begin
			blend_clamped = '0;
		end else if (poly > {5'd0, BLEND_ONE}) begin
			blend_clamped = BLEND_ONE;
		end else begin
			blend_clamped = poly[BLEND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q  <= BS_IDLE;
			cnt_q  <= '0;
			pass_q <= '0;
			res_q  <= '0;
		end else begin
			res_q.valid <= 1'b0;
			case (bst_q)
				BS_IDLE: begin
					if (go) begin
						cnt_q <= '0;
						bst_q <= BS_DIV;
					end
				end
				BS_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						pass_q <= '0;
						bst_q  <= BS_MUL;
					end
				end
				BS_MUL: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						pass_q <= pass_q + 2'd1;
						if (pass_q == 2'd3) begin
							bst_q <= BS_SUM;
						end
					end
				end
				BS_SUM: begin
					res_q.valid <= 1'b1;
					res_q.blend <= blend_clamped;
					bst_q       <= BS_IDLE;
				end
				default: begin
					bst_q <= BS_IDLE;
				end
			endcase
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		case (bst_q)
			BS_IDLE: begin
				rem_q <= elapsed;
				dvs_q <= duration;
				quo_q <= '0;
			end
			BS_DIV: begin
				rem_q <= rem_ge ? rem_diff[MS_W-1:0] : rem2[MS_W-1:0];
				quo_q <= s_new;
				if (cnt_q == 4'd15) begin
					s_q   <= s_new;
					mpl_q <= s_new;
					pw_q  <= s_new;
					acc_q <= '0;
				end
			end
			BS_MUL: begin
				if (cnt_q == 4'd15) begin
					pw_q  <= prod;
					mpl_q <= s_q;
					acc_q <= '0;
					if (pass_q == 2'd1) begin
						p3_q <= prod;
					end
					if (pass_q == 2'd2) begin
						p4_q <= prod;
					end
				end else begin
					acc_q <= prod;
					mpl_q <= mpl_q >> 1;
				end
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

[rtl/core/quintic_joint_trajectory_generator_unit.sv]
// top level of the quintic joint trajectory generator
// sequence: when the move is done (elapsed >= duration) an accepted word goes straight to the output load,
//   otherwise through the divider, the multiplier passes, polynomial, hand-over, joint lanes and load
// acceptance: a new word is taken only once the last one is loaded into the output register, as the single
//   bit-serial divide/multiply unit serves one word at a time; a stalled m_tready holds the finish state
// reset: arst_n clears the move, kept angles and all control; a tick before any start reports done
`include "assert_macros.svh"

module quintic_joint_trajectory_generator_unit import qjtg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// use_current[0], start_angle_0..3[32:1], target_angle_0..3[64:33],
	// duration_ms[80:65], elapsed_ms[96:81], zero pad[103:97]
	input  logic [103:0] s_tdata,
	// op[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// angle_0..3[63:0] (16 bits each, q8.8), done_res[64], zero pad[71:65]
	output logic [71:0]  m_tdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BLEND = 2'd1;
	localparam logic [1:0] ST_LANE  = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	// input word fields
	logic                  in_use_current;
	logic [ANGLE_W-1:0]    in_start [JOINT_COUNT];
	logic [ANGLE_W-1:0]    in_target [JOINT_COUNT];
	logic [MS_W-1:0]       in_duration;
	logic [MS_W-1:0]       in_elapsed;

	// move state
	logic [ANGLE_W-1:0]    st_q [JOINT_COUNT];
	logic [ANGLE_W-1:0]    tgt_q [JOINT_COUNT];
	logic [ANGLE_W-1:0]    kept_q [JOINT_COUNT];
	logic [MS_W-1:0]       dur_q;

	// sequencer and joint lanes
	logic [1:0]            state_q;
	logic                  done_q;
	logic [BLEND_W-1:0]    blend_q;
	logic [2:0]            lcnt_q;
	logic [ANGLE_W-1:0]    sa_q [JOINT_COUNT];
	logic [ANGLE_W-1:0]    ta_q [JOINT_COUNT];
	logic [LACC_W-1:0]     lacc_q [JOINT_COUNT];
	logic [LACC_W-1:0]     lane_next [JOINT_COUNT];
	logic [BLEND_W-1:0]    nblend;

	logic                  in_fire;
	logic [MS_W-1:0]       el_n;
	logic [MS_W-1:0]       dur_n;
	logic                  done_n;
	logic                  blend_go;
	blend_res_t            blend_res;
	logic                  out_load;
	logic [15:0]           ang [JOINT_COUNT];

	// unpack the slave word
	always_comb begin
		in_use_current = s_tdata[0];
		for (int j = 0; j < JOINT_COUNT; j++) begin
			in_start[j]  = s_tdata[1 + ANGLE_W*j +: ANGLE_W];
			in_target[j] = s_tdata[1 + ANGLE_W*(JOINT_COUNT + j) +: ANGLE_W];
		end
		in_duration = s_tdata[80:65];
		in_elapsed  = s_tdata[96:81];
	end

	// one item at a time; a finished word may still wait in the output register
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// a start answers as a tick at elapsed zero against the new duration
	always_comb begin
		dur_n  = (s_tuser == OP_START) ? in_duration : dur_q;
		el_n   = (s_tuser == OP_START) ? '0 : in_elapsed;
		done_n = (el_n >= dur_n);
	end

	// only moves still in progress need the blend; the divisor is then non-zero
	assign blend_go = in_fire && !done_n;

	qjtg_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (blend_go),
		.elapsed  (el_n),
		.duration (dur_n),
		.res      (blend_res)
	);

	// msb-first shift-add per joint: start * (1 - blend) + target * blend
	always_comb begin
		nblend = BLEND_ONE - blend_q;
		for (int j = 0; j < JOINT_COUNT; j++) begin
			lane_next[j] = {lacc_q[j][LACC_W-2:0], 1'b0}
				+ {7'd0, (sa_q[j][ANGLE_W-1] ? nblend : {BLEND_W{1'b0}})}
				+ {7'd0, (ta_q[j][ANGLE_W-1] ? blend_q : {BLEND_W{1'b0}})};
		end
	end

	// finished angles: exact targets once done, else the q8.8 part of the lane sum
	always_comb begin
		for (int j = 0; j < JOINT_COUNT; j++) begin
			ang[j] = done_q ? {tgt_q[j], 8'h00} : lacc_q[j][LACC_W-1:8];
		end
	end

	assign out_load = (state_q == ST_FIN) && (!m_tvalid || m_tready);

	// sequencer, move state and kept angles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			lcnt_q  <= '0;
			dur_q   <= '0;
			for (int j = 0; j < JOINT_COUNT; j++) begin
				st_q[j]   <= '0;
				tgt_q[j]  <= '0;
				kept_q[j] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						done_q <= done_n;
						if (s_tuser == OP_START) begin
							dur_q <= in_duration;
							for (int j = 0; j < JOINT_COUNT; j++) begin
								st_q[j]  <= in_use_current ? kept_q[j] : in_start[j];
								tgt_q[j] <= in_target[j];
							end
						end
						state_q <= done_n ? ST_FIN : ST_BLEND;
					end
				end
				ST_BLEND: begin
					lcnt_q <= '0;
					if (blend_res.valid) begin
						state_q <= ST_LANE;
					end
				end
				ST_LANE: begin
					lcnt_q <= lcnt_q + 3'd1;
					if (lcnt_q == 3'd7) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						// the floored angle is what a later move may start from
						for (int j = 0; j < JOINT_COUNT; j++) begin
							kept_q[j] <= ang[j][15:8];
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// joint lane shift registers
	always_ff @(posedge clk) begin
		if (state_q == ST_BLEND) begin
			blend_q <= blend_res.blend;
			for (int j = 0; j < JOINT_COUNT; j++) begin
				sa_q[j]   <= st_q[j];
				ta_q[j]   <= tgt_q[j];
				lacc_q[j] <= '0;
			end
		end else if (state_q == ST_LANE) begin
			for (int j = 0; j < JOINT_COUNT; j++) begin
				sa_q[j]   <= {sa_q[j][ANGLE_W-2:0], 1'b0};
				ta_q[j]   <= {ta_q[j][ANGLE_W-2:0], 1'b0};
				lacc_q[j] <= lane_next[j];
			end
		end
	end

	// output register, decouples the master side from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {7'd0, done_q, ang[3], ang[2], ang[1], ang[0]};
		end
	end

	// a done word carries the target of joint 0 exactly
	`QJTG_ASSERT_NXT(a_done_exact, out_load && done_q, (m_tdata[15:8] == $past(tgt_q[0])) && (m_tdata[7:0] == 8'h00))
	// the blend unit only answers while the sequencer waits for it
	`QJTG_ASSERT_IMP(a_blend_when_waiting, blend_res.valid, state_q == ST_BLEND)
	// the clamp keeps the blend within unity
	`QJTG_ASSERT_IMP(a_blend_range, blend_res.valid, blend_res.blend <= BLEND_ONE)
	// an accepted word always starts work
	`QJTG_ASSERT_NXT(a_accept_busy, in_fire, state_q != ST_IDLE)

endmodule
